FILE: src/label_vote_overlap_top_defines.svh
// Assertion macros shared by the label vote overlap block.
`ifndef LABEL_VOTE_OVERLAP_TOP_DEFINES_SVH
`define LABEL_VOTE_OVERLAP_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define LVO_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define LVO_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lvo_pkg.sv
package lvo_pkg;

    localparam logic [6:0]  COUNT_MAX         = 7'd127;
    localparam logic [10:0] AGREE_MAX         = 11'd2047;
    localparam logic [11:0] UNION_MAX         = 12'd4095;
    localparam logic [16:0] FRAC_ONE          = 17'd65536;
    localparam int          FRAC_BITS         = 16;
    localparam logic [6:0]  RATER_COUNT_RESET = 7'd2;
    localparam logic [6:0]  MAX_RATERS        = 7'd64;

    // One finished vertex, handed from the front to the back
    typedef struct packed {
        logic [7:0]  majority_label;
        logic [10:0] agree_pairs;
        logic [11:0] union_pairs;
        logic        count_mismatch;
    } t_vtx_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

FILE: src/lvo_front.sv
module lvo_front #(
    parameter int LABEL_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_label,
    input  logic                i_last,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data,
    output logic                o_push,
    output lvo_pkg::t_vtx_result o_push_data,
    input  logic                i_q_full
);
    import lvo_pkg::*;

    localparam int HIST_DEPTH = (LABEL_COUNT < 256) ? LABEL_COUNT : 256;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    logic [6:0]            r_rater_count;
    logic [6:0]            r_hist [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_hist_vld;
    logic [6:0]            r_hist_rd;

    logic                  r_b_vld;
    logic [7:0]            r_label;
    logic                  r_last;
    logic [6:0]            r_seen;
    logic [6:0]            r_best_cnt;
    logic [7:0]            r_best_lab;
    logic [10:0]           r_agree;
    logic [11:0]           r_union;

    logic                  r_wr_vld;
    logic [HIST_AW-1:0]    r_wr_addr;
    logic [6:0]            r_wr_val;

    logic                  b_stall;
    logic                  accept;
    logic                  b_fire;
    logic [HIST_AW-1:0]    idx;
    logic [HIST_AW-1:0]    rd_addr;
    logic                  in_range;
    logic [6:0]            h;
    logic [6:0]            h_new;
    logic                  upd;
    logic                  hist_we;
    logic [6:0]            n_seen;
    logic [11:0]           agree_sum;
    logic [12:0]           union_sum;
    logic [10:0]           n_agree;
    logic [11:0]           n_union;
    logic [6:0]            n_best_cnt;
    logic [7:0]            n_best_lab;

    // Hold the stage while a finished vertex cannot enter the queue
    assign b_stall = r_b_vld && r_last && i_q_full;
    assign accept  = i_valid && !b_stall;
    assign b_fire  = r_b_vld && !b_stall;
    assign o_stall = b_stall;

    assign idx      = r_label[HIST_AW-1:0];
    assign rd_addr  = accept ? i_label[HIST_AW-1:0] : idx;
    assign in_range = (32'(r_label) < 32'(HIST_DEPTH));

    // Count for this label, with the write of the previous cycle forwarded
    always_comb begin
        h = '0;
        if (in_range && r_hist_vld[idx]) begin
            if (r_wr_vld && (r_wr_addr == idx)) begin
                h = r_wr_val;
            end else begin
                h = r_hist_rd;
            end
        end
    end

    assign upd     = in_range && (h != COUNT_MAX);
    assign h_new   = h + 7'd1;
    assign hist_we = b_fire && upd && !r_last;
    assign n_seen  = (r_seen == COUNT_MAX) ? r_seen : r_seen + 7'd1;

    // Update pair counts and the running majority
    always_comb begin
        agree_sum  = {1'b0, r_agree} + {5'd0, h};
        union_sum  = {1'b0, r_union} + {6'd0, r_rater_count - 7'd1 - h};
        n_agree    = r_agree;
        n_union    = r_union;
        n_best_cnt = r_best_cnt;
        n_best_lab = r_best_lab;
        if (upd) begin
            n_agree = agree_sum[11] ? AGREE_MAX : agree_sum[10:0];
            if (h < r_rater_count) begin
                n_union = union_sum[12] ? UNION_MAX : union_sum[11:0];
            end
            if (h_new > r_best_cnt) begin
                n_best_cnt = h_new;
                n_best_lab = r_label;
            end
        end
    end

    assign o_push                     = b_fire && r_last;
    assign o_push_data.majority_label = n_best_lab;
    assign o_push_data.agree_pairs    = n_agree;
    assign o_push_data.union_pairs    = n_union;
    assign o_push_data.count_mismatch = (n_seen != r_rater_count);

    // Write the histogram and read the entry for the next item
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[idx] <= h_new;
        end
        r_hist_rd <= r_hist[rd_addr];
        r_wr_addr <= idx;
        r_wr_val  <= h_new;
        r_label   <= accept ? i_label : r_label;
        r_last    <= accept ? i_last : r_last;
    end

    // Advance the stage, clear per-vertex state at each vertex end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rater_count <= RATER_COUNT_RESET;
            r_b_vld       <= 1'b0;
            r_wr_vld      <= 1'b0;
            r_hist_vld    <= '0;
            r_seen        <= '0;
            r_best_cnt    <= '0;
            r_best_lab    <= '0;
            r_agree       <= '0;
            r_union       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rater_count <= (i_cfg_data > MAX_RATERS) ? MAX_RATERS : i_cfg_data;
            end
            r_b_vld  <= accept || b_stall;
            r_wr_vld <= hist_we;
            if (b_fire) begin
                if (r_last) begin
                    r_hist_vld <= '0;
                    r_seen     <= '0;
                    r_best_cnt <= '0;
                    r_best_lab <= '0;
                    r_agree    <= '0;
                    r_union    <= '0;
                end else begin
                    if (hist_we) begin
                        r_hist_vld[idx] <= 1'b1;
                    end
                    r_seen     <= n_seen;
                    r_best_cnt <= n_best_cnt;
                    r_best_lab <= n_best_lab;
                    r_agree    <= n_agree;
                    r_union    <= n_union;
                end
            end
        end
    end

endmodule

FILE: src/lvo_queue.sv
module lvo_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lvo_pkg::t_vtx_result i_push_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output lvo_pkg::t_vtx_result o_pop_data,
    output logic                 o_empty
);
    import lvo_pkg::*;

    t_vtx_result r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_pop_data = r_slot[r_rd_ptr];

    // Store a pushed vertex
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/lvo_back.sv
module lvo_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  lvo_pkg::t_vtx_result i_q_data,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_majority_label,
    output logic [10:0]          o_vertex_agree_pairs,
    output logic [11:0]          o_vertex_union_pairs,
    output logic [16:0]          o_overlap_frac,
    output logic [47:0]          o_total_agree_pairs,
    output logic [47:0]          o_total_union_pairs,
    output logic                 o_count_mismatch
);
    import lvo_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    t_vtx_result r_cur;
    logic [11:0] r_rem;
    logic [15:0] r_quo;
    logic [3:0]  r_cnt;
    logic [16:0] r_frac;

    logic        r_o_vld;
    t_vtx_result r_o_res;
    logic [16:0] r_o_frac;
    logic [47:0] r_tot_agree;
    logic [47:0] r_tot_union;

    logic        out_free;
    logic        load_out;
    logic [12:0] rem2;
    logic        q_bit;
    logic [11:0] n_rem;
    logic [15:0] n_quo;
    logic [48:0] agree_tot_sum;
    logic [48:0] union_tot_sum;

    assign out_free = !r_o_vld || !i_stall;

    // One restoring division step: remainder stays below the divisor
    assign rem2  = {r_rem, 1'b0};
    assign q_bit = (rem2 >= {1'b0, r_cur.union_pairs});
    assign n_rem = q_bit ? 12'(rem2 - {1'b0, r_cur.union_pairs}) : rem2[11:0];
    assign n_quo = {r_quo[14:0], q_bit};

    assign agree_tot_sum = {1'b0, r_tot_agree} + 49'(r_cur.agree_pairs);
    assign union_tot_sum = {1'b0, r_tot_union} + 49'(r_cur.union_pairs);

    // Sequence pop, divide and output
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if ((i_q_data.union_pairs == '0) ||
                        ({1'b0, i_q_data.agree_pairs} >= i_q_data.union_pairs)) begin
                        n_state = BK_OUT;
                    end else begin
                        n_state = BK_DIV;
                    end
                end
            end
            BK_DIV: begin
                if (r_cnt == 4'(FRAC_BITS - 1)) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load the vertex and run the quotient
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_data;
            r_rem <= {1'b0, i_q_data.agree_pairs};
            r_quo <= '0;
            r_cnt <= '0;
            if (i_q_data.union_pairs == '0) begin
                r_frac <= '0;
            end else begin
                r_frac <= FRAC_ONE;
            end
        end else if (r_state == BK_DIV) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_cnt  <= r_cnt + 4'd1;
            r_frac <= {1'b0, n_quo};
        end
        if (load_out) begin
            r_o_res  <= r_cur;
            r_o_frac <= r_frac;
        end
    end

    // Hold the result until taken, fold totals on load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld     <= 1'b0;
            r_tot_agree <= '0;
            r_tot_union <= '0;
        end else begin
            if (load_out) begin
                r_o_vld     <= 1'b1;
                r_tot_agree <= agree_tot_sum[48] ? '1 : agree_tot_sum[47:0];
                r_tot_union <= union_tot_sum[48] ? '1 : union_tot_sum[47:0];
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid              = r_o_vld;
    assign o_majority_label     = r_o_res.majority_label;
    assign o_vertex_agree_pairs = r_o_res.agree_pairs;
    assign o_vertex_union_pairs = r_o_res.union_pairs;
    assign o_overlap_frac       = r_o_frac;
    assign o_total_agree_pairs  = r_tot_agree;
    assign o_total_union_pairs  = r_tot_union;
    assign o_count_mismatch     = r_o_res.count_mismatch;

endmodule

FILE: src/label_vote_overlap_top.sv
// Throughput: one label per cycle through the histogram stage while o_stall is low;
//   the back part takes no new vertex until the last is loaded out, and its single
//   16-step quotient unit is skipped if the union is zero or agree reaches it.
// Path: front stage register, queue, back part divider, then output register.
// Reset: synchronous, active low; clears histogram valid bits, per-vertex counts,
//   totals, the queue and the output valid flag at once, and sets rater_count to 2.
`include "label_vote_overlap_top_defines.svh"

module label_vote_overlap_top #(
    parameter int LABEL_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_label,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_majority_label,
    output logic [10:0] o_vertex_agree_pairs,
    output logic [11:0] o_vertex_union_pairs,
    output logic [16:0] o_overlap_frac,
    output logic [47:0] o_total_agree_pairs,
    output logic [47:0] o_total_union_pairs,
    output logic        o_count_mismatch
);
    import lvo_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    t_vtx_result q_push_data;
    t_vtx_result q_pop_data;

    // Count labels per vertex
    lvo_front #(
        .LABEL_COUNT(LABEL_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_label     (i_label),
        .i_last      (i_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_push      (q_push),
        .o_push_data (q_push_data),
        .i_q_full    (q_full)
    );

    // Buffer finished vertices
    lvo_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty)
    );

    // Divide, total and deliver
    lvo_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_empty            (q_empty),
        .i_q_data             (q_pop_data),
        .o_pop                (q_pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_majority_label     (o_majority_label),
        .o_vertex_agree_pairs (o_vertex_agree_pairs),
        .o_vertex_union_pairs (o_vertex_union_pairs),
        .o_overlap_frac       (o_overlap_frac),
        .o_total_agree_pairs  (o_total_agree_pairs),
        .o_total_union_pairs  (o_total_union_pairs),
        .o_count_mismatch     (o_count_mismatch)
    );

    `LVO_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, q_push, !q_full, "push into full queue")
    `LVO_ASSERT_SAME(a_no_pop_when_empty, i_clk, i_rst_n, q_pop, !q_empty, "pop from empty queue")
    `LVO_ASSERT_SAME(a_frac_zero_union, i_clk, i_rst_n, o_valid && (o_vertex_union_pairs == '0), o_overlap_frac == '0, "nonzero fraction with empty union")
    `LVO_ASSERT_NEXT(a_frac_bound, i_clk, i_rst_n, q_pop, !o_valid || (o_overlap_frac <= FRAC_ONE), "fraction above one")

endmodule
